// ===== design/spi_pkg.sv =====
// Shared types and codes for the sampled path interpolator.
package spi_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [3:0] WS_POS_X = 4'd0;
  localparam logic [3:0] WS_TAN_X = 4'd3;
  localparam logic [3:0] WS_ARC   = 4'd9;
  localparam logic [3:0] WS_TAG   = 4'd10;
  localparam logic [3:0] WS_CHAIN = 4'd11;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LOOP_CLOSED  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SPACING      = 2'd2;

  localparam logic [23:0] SPACING_RESET = 24'd65536;
  localparam logic [15:0] UNIT_Q14      = 16'd16384;

  typedef struct packed {
    logic               command;
    logic [11:0]        entry_index;
    logic [3:0]         word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] query_u;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] arc_length;
    logic [7:0]         tag_out;
    logic               chain_out;
  } out_item_t;

endpackage

// ===== design/spi_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module spi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/sampled_path_interpolator.sv =====
// Sampled path interpolator: table of path samples with lerp and renormalising lookups.
//
// Input channel (in_valid/in_ready/in_item) carries two kinds of transaction.
// A write loads one word of one table entry and gives no result. A query
// interpolates the path at u and gives exactly one result on the output
// channel (out_valid/out_ready/out_item), in order of acceptance.
// Configuration (sample count, closed loop, spacing) is written over the cfg_
// channel while the block is idle; the user must keep to this, as the block
// itself does not enforce it; cfg_ready is always high. One transaction is
// accepted per cycle sustained while the output is not held back; the rate is
// set by the two-read table port, each table read and write occupying one fixed
// pipeline stage. Writes and reads meet the table at that same stage, so a
// query sees every write accepted before it and none after.
// The index wrap, square root and normalising divides run as pipelined
// compare-and-subtract steps, eight or fewer to a stage.
// Reset empties the pipeline and restores the configuration defaults; the
// table is left as it is and holds nothing defined until written.
// When out_ready is low the result holds, bubbles close up and in_ready falls
// only once every stage holds a transaction.
module sampled_path_interpolator #(
  parameter int MAX_SAMPLES   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spi_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spi_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spi_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [spi_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int IW   = $clog2(MAX_SAMPLES);
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int AW   = NW + 17;
  localparam int FW   = FRACTION_BITS;
  localparam int UPSH = (FW > 16) ? FW - 16 : 0;
  localparam int DNSH = (FW < 16) ? 16 - FW : 0;
  localparam int PPW  = 34 + FW;
  localparam int LPW  = PPW + 1;
  localparam int PFW  = 18 + FW;
  localparam int FLW  = PFW + 1;
  localparam int PAW  = 24 + FW;

  localparam logic signed [LPW-1:0] P_HALF  = LPW'(1) << (FW - 1);
  localparam logic signed [FLW-1:0] F_HALF  = FLW'(1) << (FW - 1);
  localparam logic [PAW-1:0]        A_HALF  = PAW'(1) << (FW - 1);
  localparam logic signed [LPW-1:0] S32_MAX = (LPW'(1) << 31) - LPW'(1);
  localparam logic signed [LPW-1:0] S32_MIN = -(LPW'(1) << 31);

  typedef struct packed {
    logic            cmd;
    logic [11:0]     widx;
    logic [3:0]      ws;
    logic [31:0]     wv;
    logic [IW-1:0]   iopen;
    logic [FW-1:0]   f;
  } front_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [31:0]      arc;
    logic [7:0]       tag;
    logic             chain;
    logic [2:0][15:0] tv;
    logic [2:0][15:0] uv;
    logic             st_zero;
    logic             su_small;
  } carry_t;

  typedef struct packed {
    logic [61:0] v;
    logic [61:0] r;
  } sq_t;

  typedef struct packed {
    carry_t c;
    sq_t    t;
    sq_t    u;
  } sc_t;

  typedef struct packed {
    carry_t           c;
    logic [30:0]      rt;
    logic [30:0]      ru;
    logic [5:0][45:0] rem;
    logic [5:0][15:0] q;
  } dv_t;

  function automatic logic [AW-1:0] mod_step(input logic [AW-1:0] rem,
                                             input logic [NW-1:0] n, input int k);
    logic [AW-1:0] dv;
    dv = AW'(n) << k;
    return (rem >= dv) ? rem - dv : rem;
  endfunction

  function automatic sq_t isq_step(input sq_t x, input int k);
    logic [61:0] b;
    logic [61:0] s;
    sq_t         y;
    b = 62'(1) << (2 * k);
    s = x.r + b;
    y = x;
    if (x.v >= s) begin
      y.v = x.v - s;
      y.r = (x.r >> 1) + b;
    end else begin
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  function automatic logic [15:0] mag16(input logic [15:0] x);
    logic [16:0] ng;
    ng = 17'd0 - {x[15], x};
    return x[15] ? ng[15:0] : x;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [LPW-1:0] x);
    if (x > S32_MAX) begin
      return 32'h7fff_ffff;
    end else if (x < S32_MIN) begin
      return 32'h8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

  // configuration
  logic [NW-1:0] n_r;
  logic          closed_r;
  logic [23:0]   spacing_r;
  logic [31:0]   cnt32;
  logic [NW-1:0] n_cfg;

  assign cfg_ready = 1'b1;
  assign cnt32     = 32'(cfg_data[12:0]);
  assign n_cfg     = (cnt32 > 32'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(cnt32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= '0;
      closed_r  <= 1'b0;
      spacing_r <= spi_pkg::SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spi_pkg::CFG_SAMPLE_COUNT: n_r       <= n_cfg;
        spi_pkg::CFG_LOOP_CLOSED:  closed_r  <= cfg_data[0];
        spi_pkg::CFG_SPACING:      spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic [16:1] v_r;
  logic [16:1] rdy;

  always_comb begin
    rdy[16] = !v_r[16] || out_ready;
    for (int k = 15; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[16];

  front_t            fr_r  [2:5];
  logic [AW-1:0]     rem_r [2:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= 16; k++) begin
        if (rdy[k]) begin
          if (k == 6) begin
            v_r[k] <= v_r[5] && (fr_r[5].cmd == spi_pkg::CMD_QUERY);
          end else begin
            v_r[k] <= v_r[k-1];
          end
        end
      end
    end
  end

  // stage 1: accepted transaction
  spi_pkg::in_item_t s1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_r <= in_item;
    end
  end

  // split u, clamp for an open path, offset for the wrap
  front_t          fr2_nxt;
  logic [AW-1:0]   rem2_nxt;
  logic [15:0]     ipart;
  logic [FW-1:0]   f_full;
  logic [31:0]     n32;
  logic [31:0]     ipu;
  logic signed [AW:0] a_s;

  always_comb begin
    ipart  = s1_r.query_u[31:16];
    f_full = FW'((32'(s1_r.query_u[15:0]) << UPSH) >> DNSH);
    n32    = 32'(n_r);
    ipu    = 32'(ipart);
    a_s    = $signed({{(AW-15){ipart[15]}}, ipart}) + $signed({1'b0, AW'(n_r) << 15});
    fr2_nxt.cmd  = s1_r.command;
    fr2_nxt.widx = s1_r.entry_index;
    fr2_nxt.ws   = s1_r.word_select;
    fr2_nxt.wv   = s1_r.word_value;
    if (n32 <= 32'd1) begin
      fr2_nxt.iopen = '0;
      fr2_nxt.f     = '0;
    end else if (closed_r) begin
      fr2_nxt.iopen = '0;
      fr2_nxt.f     = f_full;
    end else if (s1_r.query_u[31]) begin
      fr2_nxt.iopen = '0;
      fr2_nxt.f     = '0;
    end else if (ipu >= n32 - 32'd1) begin
      fr2_nxt.iopen = IW'(n32 - 32'd1);
      fr2_nxt.f     = '0;
    end else begin
      fr2_nxt.iopen = IW'(ipu);
      fr2_nxt.f     = f_full;
    end
    rem2_nxt = a_s[AW-1:0];
  end

  // index modulo count: seventeen restoring steps over three stages
  logic [AW-1:0] rem_nxt [3];

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      rem_nxt[g] = rem_r[2+g];
      for (int q = 0; q < 6; q++) begin
        if (q < ((g == 2) ? 5 : 6)) begin
          rem_nxt[g] = mod_step(rem_nxt[g], n_r, 16 - 6 * g - q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      fr_r[2]  <= fr2_nxt;
      rem_r[2] <= rem2_nxt;
    end
    for (int g = 0; g < 3; g++) begin
      if (rdy[3+g]) begin
        fr_r[3+g]  <= fr_r[2+g];
        rem_r[3+g] <= rem_nxt[g];
      end
    end
  end

  // stage 5: table access, reads of entries i and i+1 (wrapping to entry 0), or the write
  logic [IW-1:0] i5;
  logic [IW:0]   ip1;
  logic [IW-1:0] j5;
  logic [16:0]   widx_ext;
  logic [IW-1:0] waddr;
  logic          wr_ok;

  always_comb begin
    i5       = closed_r ? rem_r[5][IW-1:0] : fr_r[5].iopen;
    ip1      = {1'b0, i5} + (IW+1)'(1);
    j5       = (32'(ip1) < 32'(n_r)) ? ip1[IW-1:0] : '0;
    widx_ext = 17'(fr_r[5].widx);
    waddr    = widx_ext[IW-1:0];
    wr_ok    = v_r[5] && rdy[6] && (fr_r[5].cmd == spi_pkg::CMD_WRITE) &&
               (32'(fr_r[5].widx) < 32'(MAX_SAMPLES)) && (fr_r[5].ws <= spi_pkg::WS_CHAIN);
  end

  logic [31:0] pos_a [3];
  logic [31:0] pos_b [3];
  logic [15:0] frm_a [6];
  logic [15:0] frm_b [6];
  logic [31:0] arc_a;
  logic [7:0]  tag_a;
  logic        chain_a;

  for (genvar k = 0; k < 3; k++) begin : g_pos
    spi_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_pos (
      .clk     (clk),
      .we      (wr_ok && (fr_r[5].ws == spi_pkg::WS_POS_X + 4'(k))),
      .waddr   (waddr),
      .wdata   (fr_r[5].wv),
      .re      (rdy[6]),
      .raddr_a (i5),
      .raddr_b (j5),
      .rdata_a (pos_a[k]),
      .rdata_b (pos_b[k])
    );
  end

  for (genvar k = 0; k < 6; k++) begin : g_frm
    spi_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_frm (
      .clk     (clk),
      .we      (wr_ok && (fr_r[5].ws == spi_pkg::WS_TAN_X + 4'(k))),
      .waddr   (waddr),
      .wdata   (fr_r[5].wv[15:0]),
      .re      (rdy[6]),
      .raddr_a (i5),
      .raddr_b (j5),
      .rdata_a (frm_a[k]),
      .rdata_b (frm_b[k])
    );
  end

  spi_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_arc (
    .clk     (clk),
    .we      (wr_ok && (fr_r[5].ws == spi_pkg::WS_ARC)),
    .waddr   (waddr),
    .wdata   (fr_r[5].wv),
    .re      (rdy[6]),
    .raddr_a (i5),
    .raddr_b (j5),
    .rdata_a (arc_a),
    .rdata_b ()
  );

  spi_ram #(.WIDTH(8), .DEPTH(MAX_SAMPLES)) u_tag (
    .clk     (clk),
    .we      (wr_ok && (fr_r[5].ws == spi_pkg::WS_TAG)),
    .waddr   (waddr),
    .wdata   (fr_r[5].wv[7:0]),
    .re      (rdy[6]),
    .raddr_a (i5),
    .raddr_b (j5),
    .rdata_a (tag_a),
    .rdata_b ()
  );

  spi_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_chain (
    .clk     (clk),
    .we      (wr_ok && (fr_r[5].ws == spi_pkg::WS_CHAIN)),
    .waddr   (waddr),
    .wdata   (fr_r[5].wv[0]),
    .re      (rdy[6]),
    .raddr_a (i5),
    .raddr_b (j5),
    .rdata_a (chain_a),
    .rdata_b ()
  );

  // stage 6 holds the fraction next to the read data
  logic [FW-1:0] f6_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      f6_r <= fr_r[5].f;
    end
  end

  // stage 7: differences
  logic signed [31:0] apos7 [3];
  logic signed [32:0] dpos7 [3];
  logic signed [15:0] afr7  [6];
  logic signed [16:0] dfr7  [6];
  logic signed [31:0] arc7;
  logic [7:0]         tag7;
  logic               chain7;
  logic [FW-1:0]      f7;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int k = 0; k < 3; k++) begin
        apos7[k] <= pos_a[k];
        dpos7[k] <= $signed({pos_b[k][31], pos_b[k]}) - $signed({pos_a[k][31], pos_a[k]});
      end
      for (int k = 0; k < 6; k++) begin
        afr7[k] <= frm_a[k];
        dfr7[k] <= $signed({frm_b[k][15], frm_b[k]}) - $signed({frm_a[k][15], frm_a[k]});
      end
      arc7   <= arc_a;
      tag7   <= tag_a;
      chain7 <= chain_a;
      f7     <= f6_r;
    end
  end

  // stage 8: products
  logic signed [31:0]     apos8 [3];
  logic signed [PPW-1:0]  ppos8 [3];
  logic signed [15:0]     afr8  [6];
  logic signed [PFW-1:0]  pfr8  [6];
  logic signed [31:0]     arc8;
  logic [PAW-1:0]         parc8;
  logic [7:0]             tag8;
  logic                   chain8;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int k = 0; k < 3; k++) begin
        apos8[k] <= apos7[k];
        ppos8[k] <= dpos7[k] * $signed({1'b0, f7});
      end
      for (int k = 0; k < 6; k++) begin
        afr8[k] <= afr7[k];
        pfr8[k] <= dfr7[k] * $signed({1'b0, f7});
      end
      arc8   <= arc7;
      parc8  <= PAW'(f7) * PAW'(spacing_r);
      tag8   <= tag7;
      chain8 <= chain7;
    end
  end

  // lerp sums, rounded half up
  carry_t             c9_nxt;
  logic signed [LPW-1:0] lp;
  logic signed [FLW-1:0] lf;
  logic [PAW-1:0]        arc_add;

  always_comb begin
    c9_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      lp = ($signed(LPW'(ppos8[k])) + P_HALF) >>> FW;
      c9_nxt.pos[k] = sat32($signed(LPW'(apos8[k])) + lp);
    end
    for (int k = 0; k < 6; k++) begin
      lf = ($signed(FLW'(pfr8[k])) + F_HALF) >>> FW;
      if (k < 3) begin
        c9_nxt.tv[k] = afr8[k] + lf[15:0];
      end else begin
        c9_nxt.uv[k-3] = afr8[k] + lf[15:0];
      end
    end
    arc_add      = (parc8 + A_HALF) >> FW;
    c9_nxt.arc   = sat32($signed(LPW'(arc8)) + $signed(LPW'(arc_add)));
    c9_nxt.tag   = tag8;
    c9_nxt.chain = chain8;
  end

  carry_t c9_r;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      c9_r <= c9_nxt;
    end
  end

  // squared lengths
  sc_t         sc10_nxt;
  logic [31:0] st;
  logic [31:0] su;
  logic [15:0] mt;
  logic [15:0] mu;

  always_comb begin
    st = '0;
    su = '0;
    for (int k = 0; k < 3; k++) begin
      mt = mag16(c9_r.tv[k]);
      mu = mag16(c9_r.uv[k]);
      st = st + 32'(mt) * 32'(mt);
      su = su + 32'(mu) * 32'(mu);
    end
    sc10_nxt.c          = c9_r;
    sc10_nxt.c.st_zero  = (st == 32'd0);
    sc10_nxt.c.su_small = (su <= 32'd2);
    sc10_nxt.t.v        = 62'(st) << 28;
    sc10_nxt.t.r        = '0;
    sc10_nxt.u.v        = 62'(su) << 28;
    sc10_nxt.u.r        = '0;
  end

  // square roots: thirty steps over four stages
  sc_t sc_r   [10:14];
  sc_t sc_nxt [4];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      sc_nxt[g] = sc_r[10+g];
      for (int q = 0; q < 8; q++) begin
        if (q < ((g == 3) ? 6 : 8)) begin
          sc_nxt[g].t = isq_step(sc_nxt[g].t, 29 - 8 * g - q);
          sc_nxt[g].u = isq_step(sc_nxt[g].u, 29 - 8 * g - q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      sc_r[10] <= sc10_nxt;
    end
    for (int g = 0; g < 4; g++) begin
      if (rdy[11+g]) begin
        sc_r[11+g] <= sc_nxt[g];
      end
    end
  end

  // normalising divides, upper quotient bits
  dv_t         dv15_nxt;
  logic [30:0] dvsr;
  logic [45:0] dsh;
  logic [15:0] mc;

  always_comb begin
    dv15_nxt.c  = sc_r[14].c;
    dv15_nxt.rt = sc_r[14].t.r[30:0];
    dv15_nxt.ru = sc_r[14].u.r[30:0];
    for (int k = 0; k < 6; k++) begin
      dvsr = (k < 3) ? dv15_nxt.rt : dv15_nxt.ru;
      mc   = (k < 3) ? mag16(sc_r[14].c.tv[k]) : mag16(sc_r[14].c.uv[k-3]);
      dv15_nxt.rem[k] = (46'(mc) << 28) + 46'(dvsr >> 1);
      dv15_nxt.q[k]   = '0;
      for (int q = 0; q < 8; q++) begin
        dsh = 46'(dvsr) << (15 - q);
        if (dv15_nxt.rem[k] >= dsh) begin
          dv15_nxt.rem[k]      = dv15_nxt.rem[k] - dsh;
          dv15_nxt.q[k][15-q]  = 1'b1;
        end
      end
    end
  end

  dv_t dv_r;

  always_ff @(posedge clk) begin
    if (rdy[15]) begin
      dv_r <= dv15_nxt;
    end
  end

  // lower quotient bits, saturation, sign and the special cases
  logic [15:0]        qfin [6];
  logic [45:0]        rrem;
  logic [30:0]        dvsr2;
  logic [45:0]        dsh2;
  logic [15:0]        qs;
  logic [15:0]        nv   [6];
  spi_pkg::out_item_t out_nxt;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dvsr2   = (k < 3) ? dv_r.rt : dv_r.ru;
      rrem    = dv_r.rem[k];
      qfin[k] = dv_r.q[k];
      for (int q = 0; q < 8; q++) begin
        dsh2 = 46'(dvsr2) << (7 - q);
        if (rrem >= dsh2) begin
          rrem          = rrem - dsh2;
          qfin[k][7-q]  = 1'b1;
        end
      end
      qs = (qfin[k] > 16'd32767) ? 16'd32767 : qfin[k];
      if (k < 3) begin
        nv[k] = dv_r.c.tv[k][15] ? 16'd0 - qs : qs;
      end else begin
        nv[k] = dv_r.c.uv[k-3][15] ? 16'd0 - qs : qs;
      end
    end

    out_nxt.pos_x      = dv_r.c.pos[0];
    out_nxt.pos_y      = dv_r.c.pos[1];
    out_nxt.pos_z      = dv_r.c.pos[2];
    out_nxt.arc_length = dv_r.c.arc;
    out_nxt.tag_out    = dv_r.c.tag;
    out_nxt.chain_out  = dv_r.c.chain;
    if (n_r == NW'(1)) begin
      // single sample: stored frame as it is
      out_nxt.tan_x = dv_r.c.tv[0];
      out_nxt.tan_y = dv_r.c.tv[1];
      out_nxt.tan_z = dv_r.c.tv[2];
      out_nxt.up_x  = dv_r.c.uv[0];
      out_nxt.up_y  = dv_r.c.uv[1];
      out_nxt.up_z  = dv_r.c.uv[2];
    end else begin
      out_nxt.tan_x = dv_r.c.st_zero ? 16'd0 : nv[0];
      out_nxt.tan_y = dv_r.c.st_zero ? 16'd0 : nv[1];
      out_nxt.tan_z = dv_r.c.st_zero ? 16'd0 : nv[2];
      out_nxt.up_x  = dv_r.c.su_small ? 16'd0 : nv[3];
      out_nxt.up_y  = dv_r.c.su_small ? spi_pkg::UNIT_Q14 : nv[4];
      out_nxt.up_z  = dv_r.c.su_small ? 16'd0 : nv[5];
    end
    if (n_r == '0) begin
      out_nxt = '0;
    end
  end

  spi_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[16]) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

  // the pipeline only backs up when the result is refused
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output was free");

  // a non-zero tangent never needs the quotient clamp
  a_tan_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[15] && !dv_r.c.st_zero) |->
      (!qfin[0][15] && !qfin[1][15] && !qfin[2][15]))
    else $error("tangent quotient out of range");

endmodule

// ===== verif/sampled_path_interpolator_tb.sv =====
// Self-checking testbench for the sampled path interpolator: table loads, path queries.
module sampled_path_interpolator_tb;
  import spi_pkg::*;

  localparam int  TABLE_DEPTH = 4096;
  localparam int  LATENCY     = 15;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  PHASE_ITEMS = 210;
  localparam logic [3:0] WS_UP_X   = WS_TAN_X + 4'd3;
  localparam logic [3:0] WS_NONE   = 4'hF;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    in_item_t    item;
    logic        typed;
    out_item_t   want;
    logic [12:0] count;
    logic        closed;
    logic [23:0] spacing;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  sampled_path_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the path table and registers
  logic signed [31:0] pos_mem   [TABLE_DEPTH][3];
  logic signed [15:0] frame_mem [TABLE_DEPTH][6];
  logic signed [31:0] arc_mem   [TABLE_DEPTH];
  logic [7:0]         tag_mem   [TABLE_DEPTH];
  logic               chain_mem [TABLE_DEPTH];
  logic [11:0]        words_loaded [TABLE_DEPTH];
  logic [12:0] cur_count   = '0;
  logic        cur_closed  = 1'b0;
  logic [23:0] cur_spacing = SPACING_RESET;

  out_item_t pending_poses[$];
  int  errors = 0;
  int  cyc = 0;
  int  send_idle_pct = 25;
  int  recv_idle_pct = 86;
  int  hold_left = 0;
  row_t rows[$];

  function automatic longint lerp(longint a, longint b, longint f);
    return a + (((b - a) * f + 64'sd32768) >>> 16);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit vector in Q2.14; returns the squared length
  function automatic longint unsigned unit_vec(input longint v0, v1, v2,
                                               output longint o0, o1, o2);
    longint v [3];
    longint o [3];
    longint unsigned s, r, m, q;
    v[0] = v0; v[1] = v1; v[2] = v2;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      s += m * m;
    end
    o[0] = 0; o[1] = 0; o[2] = 0;
    if (s != 0) begin
      r = int_sqrt(s << 28);
      for (int k = 0; k < 3; k++) begin
        m = v[k] < 0 ? -v[k] : v[k];
        q = ((m << 28) + r / 2) / r;
        if (q > 32767) q = 32767;
        o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
      end
    end
    o0 = o[0]; o1 = o[1]; o2 = o[2];
    return s;
  endfunction

  function automatic out_item_t interpolate_at(logic signed [31:0] query_u);
    out_item_t res;
    longint n, u, span, i, j, f, add;
    longint tv [3];
    longint uv [3];
    longint t0, t1, t2, w0, w1, w2;
    res = '0;
    n = cur_count > TABLE_DEPTH ? TABLE_DEPTH : cur_count;
    if (n == 1) begin
      res.pos_x = pos_mem[0][0]; res.pos_y = pos_mem[0][1]; res.pos_z = pos_mem[0][2];
      res.tan_x = frame_mem[0][0]; res.tan_y = frame_mem[0][1]; res.tan_z = frame_mem[0][2];
      res.up_x = frame_mem[0][3]; res.up_y = frame_mem[0][4]; res.up_z = frame_mem[0][5];
      res.arc_length = arc_mem[0];
      res.tag_out = tag_mem[0];
      res.chain_out = chain_mem[0];
    end else if (n >= 2) begin
      u = query_u;
      if (cur_closed) begin
        span = n << 16;
        u = u % span;
        if (u < 0) u += span;
      end else begin
        u = sat(u, 0, (n - 1) << 16);
      end
      i = u >> 16;
      f = u & 64'hFFFF;
      j = (i + 1 < n) ? i + 1 : 0;
      res.pos_x = sat(lerp(pos_mem[i][0], pos_mem[j][0], f), -(64'sd1 << 31), (64'sd1 << 31) - 1);
      res.pos_y = sat(lerp(pos_mem[i][1], pos_mem[j][1], f), -(64'sd1 << 31), (64'sd1 << 31) - 1);
      res.pos_z = sat(lerp(pos_mem[i][2], pos_mem[j][2], f), -(64'sd1 << 31), (64'sd1 << 31) - 1);
      for (int k = 0; k < 3; k++) begin
        tv[k] = lerp(frame_mem[i][k], frame_mem[j][k], f);
        uv[k] = lerp(frame_mem[i][3+k], frame_mem[j][3+k], f);
      end
      void'(unit_vec(tv[0], tv[1], tv[2], t0, t1, t2));
      // up collapsing to near nothing falls back to world up
      if (unit_vec(uv[0], uv[1], uv[2], w0, w1, w2) <= 2) begin
        w0 = 0; w1 = UNIT_Q14; w2 = 0;
      end
      res.tan_x = t0; res.tan_y = t1; res.tan_z = t2;
      res.up_x = w0; res.up_y = w1; res.up_z = w2;
      add = (f * longint'(cur_spacing) + 32768) >> 16;
      res.arc_length = sat(longint'(arc_mem[i]) + add, -(64'sd1 << 31), (64'sd1 << 31) - 1);
      res.tag_out = tag_mem[i];
      res.chain_out = chain_mem[i];
    end
    return res;
  endfunction

  function automatic void store_word(in_item_t it);
    int e, w;
    e = it.entry_index;
    w = it.word_select;
    if (w > WS_CHAIN) return;
    words_loaded[e][w] = 1'b1;
    if (w < WS_TAN_X) pos_mem[e][w] = it.word_value;
    else if (w < WS_ARC) frame_mem[e][w - WS_TAN_X] = it.word_value[15:0];
    else if (w == WS_ARC) arc_mem[e] = it.word_value;
    else if (w == WS_TAG) tag_mem[e] = it.word_value[7:0];
    else chain_mem[e] = it.word_value[0];
  endfunction

  // flat: tangent words go to zero, up words to a near-null vector
  function automatic logic [31:0] gen_word(int w, bit flat);
    logic [31:0] r;
    logic [15:0] lo;
    r = $urandom;
    if (w < WS_TAN_X) begin
      case ($urandom_range(4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        default: return r;
      endcase
    end
    if (w < WS_ARC) begin
      if (flat) lo = (w >= WS_UP_X) ? 16'($signed($urandom_range(2)) - 1) : 16'd0;
      else begin
        case ($urandom_range(5))
          0: lo = 16'h7FFF;
          1: lo = 16'h8000;
          default: lo = r[15:0];
        endcase
      end
      return {r[31:16], lo};
    end
    if (w == WS_ARC && $urandom_range(3) == 0) return {16'h7FFF, r[15:0]};
    return r;
  endfunction

  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.command == CMD_QUERY) pending_poses.push_back(typed ? want : interpolate_at(it.query_u));
    else store_word(it);
  endtask

  task automatic send_write(int e, int w, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.command = CMD_WRITE;
    it.entry_index = e;
    it.word_select = w;
    it.word_value = v;
    it.query_u = $urandom;
    send_item(it, 1'b0, '0);
  endtask

  task automatic set_config(logic [12:0] count, logic closed, logic [23:0] spacing);
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= k == 0 ? CFG_SAMPLE_COUNT : (k == 1 ? CFG_LOOP_CLOSED : CFG_SPACING);
      cfg_data  <= k == 0 ? 24'(count) : (k == 1 ? 24'(closed) : spacing);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_count = count;
    cur_closed = closed;
    cur_spacing = spacing;
  endtask

  // Every entry a query may touch must be fully loaded first
  task automatic fill_entries(int n);
    bit flat_tan, flat_up;
    for (int e = 0; e < n && e < TABLE_DEPTH; e++) begin
      flat_tan = $urandom_range(3) == 0;
      flat_up  = $urandom_range(3) == 0;
      for (int w = 0; w <= WS_CHAIN; w++)
        if (!words_loaded[e][w]) send_write(e, w, gen_word(w, w < WS_UP_X ? flat_tan : flat_up));
    end
  endtask

  task automatic random_phase(logic [12:0] count, logic closed, logic [23:0] spacing);
    in_item_t it;
    int n;
    logic [15:0] frac;
    n = count > TABLE_DEPTH ? TABLE_DEPTH : count;
    fill_entries(n);
    set_config(count, closed, spacing);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if ($urandom_range(9) < 3) begin
        send_write($urandom_range(TABLE_DEPTH - 1), $urandom_range(15),
                   gen_word($urandom_range(11), $urandom_range(3) == 0));
      end else begin
        it = '0;
        it.command = CMD_QUERY;
        it.entry_index = $urandom;
        it.word_select = $urandom;
        it.word_value = $urandom;
        if ($urandom_range(9) < 4) it.query_u = $urandom;
        else begin
          case ($urandom_range(3))
            0: frac = 16'h0000;
            1: frac = 16'hFFFF;
            2: frac = 16'h8000;
            default: frac = $urandom;
          endcase
          it.query_u = {16'($signed($urandom_range(2 * n + 4)) - n - 2), frac};
        end
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  function automatic row_t item_row(logic cmd, int e, logic [3:0] w, logic [31:0] v,
                                    logic [31:0] u, logic typed, out_item_t want);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.command = cmd;
    r.item.entry_index = e;
    r.item.word_select = w;
    r.item.word_value = v;
    r.item.query_u = u;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [12:0] count, logic closed, logic [23:0] spacing);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.count = count;
    r.closed = closed;
    r.spacing = spacing;
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
      end else begin
        want = pending_poses.pop_front();
        check_field("pos_x", want.pos_x, out_item.pos_x);
        check_field("pos_y", want.pos_y, out_item.pos_y);
        check_field("pos_z", want.pos_z, out_item.pos_z);
        check_field("tan_x", want.tan_x, out_item.tan_x);
        check_field("tan_y", want.tan_y, out_item.tan_y);
        check_field("tan_z", want.tan_z, out_item.tan_z);
        check_field("up_x", want.up_x, out_item.up_x);
        check_field("up_y", want.up_y, out_item.up_y);
        check_field("up_z", want.up_z, out_item.up_z);
        check_field("arc_length", want.arc_length, out_item.arc_length);
        check_field("tag_out", want.tag_out, out_item.tag_out);
        check_field("chain_out", want.chain_out, out_item.chain_out);
      end
    end
  end

  // Long receiver hold-offs so the pipeline fills and backs up
  always @(posedge clk) begin
    if (cyc % 25000 == 5000) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_item_t zero_pose, entry0_pose;
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      words_loaded[e] = '0;
      for (int k = 0; k < 3; k++) pos_mem[e][k] = '0;
      for (int k = 0; k < 6; k++) frame_mem[e][k] = '0;
      arc_mem[e] = '0;
      tag_mem[e] = '0;
      chain_mem[e] = 1'b0;
    end
    zero_pose = '0;
    entry0_pose = out_item_t'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                              16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
                              32'h7FFF_FFFF, 8'hA5, 1'b1};

    // Empty table gives an all-zero pose; a single entry comes back as stored
    rows.push_back(item_row(CMD_QUERY, 0, 0, 0, 32'h0000_0000, 1'b1, zero_pose));
    rows.push_back(item_row(CMD_QUERY, 4095, WS_NONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, zero_pose));
    rows.push_back(item_row(CMD_QUERY, 0, 0, 0, 32'h8000_0000, 1'b1, zero_pose));
    rows.push_back(item_row(CMD_WRITE, 0, WS_POS_X,     32'h7FFF_FFFF, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_POS_X + 1, 32'h8000_0000, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_POS_X + 2, 32'h0001_0000, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_TAN_X,     32'h1234_7FFF, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_TAN_X + 1, 32'hFFFF_8000, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_TAN_X + 2, 32'hABCD_0000, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_UP_X,      32'h0000_0000, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_UP_X + 1,  32'h8000_0001, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_UP_X + 2,  32'h0000_FFFF, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_ARC,       32'h7FFF_FFFF, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_TAG,       32'hFFFF_FFA5, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_CHAIN,     32'h0000_0003, 0, 1'b0, '0));
    // word selects past the chain flag are dropped
    rows.push_back(item_row(CMD_WRITE, 0, WS_CHAIN + 1, 32'hFFFF_FFFF, 0, 1'b0, '0));
    rows.push_back(item_row(CMD_WRITE, 0, WS_NONE,      32'h0000_0000, 0, 1'b0, '0));
    rows.push_back(cfg_row(13'd1, 1'b1, 24'hFF_FFFF));
    rows.push_back(item_row(CMD_QUERY, 0, 0, 0, 32'h1234_5678, 1'b1, entry0_pose));
    rows.push_back(item_row(CMD_QUERY, 0, 0, 0, 32'h8000_0000, 1'b1, entry0_pose));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) set_config(rows[r].count, rows[r].closed, rows[r].spacing);
      else send_item(rows[r].item, rows[r].typed, rows[r].want);
    end

    random_phase(13'd2, 1'b0, 24'd0);
    random_phase(13'd2, 1'b1, 24'hFF_FFFF);
    random_phase(13'd3, 1'b1, SPACING_RESET);
    send_idle_pct = 86;
    recv_idle_pct = 25;
    random_phase(13'd5, 1'b0, 24'($urandom));
    random_phase(13'd17, 1'b1, 24'($urandom));
    random_phase(13'd1, 1'b0, 24'($urandom));
    random_phase(13'd0, 1'b1, 24'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(13'd8191, 1'b0, 24'($urandom));
    random_phase(13'd4096, 1'b1, 24'hFF_FFFF);

    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (LATENCY * 3) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== sampled_path_interpolator.f =====
design/spi_pkg.sv
design/spi_ram.sv
design/sampled_path_interpolator.sv
verif/sampled_path_interpolator_tb.sv
